### design/cdsd_pkg.sv
// shared types, constants and helper functions for the countdown segment display encoder
// no dependencies; used by cdsd_split, cdsd_serial and the top level
package cdsd_pkg;

    localparam int unsigned NUM_DIG = 9;

    // digit slots of the mixed-radix number, least significant first
    localparam int unsigned D_C0 = 0;
    localparam int unsigned D_C1 = 1;
    localparam int unsigned D_S0 = 2;
    localparam int unsigned D_S1 = 3;
    localparam int unsigned D_M0 = 4;
    localparam int unsigned D_M1 = 5;
    localparam int unsigned D_H0 = 6;
    localparam int unsigned D_H1 = 7;
    localparam int unsigned D_H2 = 8;

    localparam logic [31:0] MS_10S  = 32'd10000;
    localparam logic [31:0] MS_1MIN = 32'd60000;
    localparam logic [31:0] MS_10MIN = 32'd600000;
    localparam logic [31:0] MS_1H   = 32'd3600000;
    localparam logic [31:0] MS_10H  = 32'd36000000;

    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

    // floor(2^k / divisor) reciprocals; quotient is exact or one low
    localparam logic [10:0] RECIP_HOUR = 11'd1193;
    localparam logic [6:0]  RECIP_MIN  = 7'd69;
    localparam logic [6:0]  RECIP_SEC  = 7'd65;
    // exact reciprocals for small operands
    localparam logic [7:0]  RECIP_TEN     = 8'd205;
    localparam logic [5:0]  RECIP_HUNDRED = 6'd41;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic [31:0]               mag;
        logic [2:0]                shift;
        logic [9:0]                hours;
        logic [22:0]               rem;
        logic [5:0]                mins;
        logic [5:0]                secs;
        logic [6:0]                centis;
        logic [6:0]                hrem;
        t_digit [NUM_DIG-1:0]      digits;
    } t_work;

    typedef struct packed {
        t_digit [NUM_DIG-1:0]      digits;
        logic [2:0]                shift;
    } t_item;

    function automatic logic [13:0] seg_code(input t_digit d);
        logic [13:0] s;
        case (d)
            4'd0:    s = 14'b00111111111111;
            4'd1:    s = 14'b00000011110000;
            4'd2:    s = 14'b11111100111100;
            4'd3:    s = 14'b10001111111100;
            4'd4:    s = 14'b11000011110011;
            4'd5:    s = 14'b11001111001111;
            4'd6:    s = 14'b11111111001111;
            4'd7:    s = 14'b00000011111100;
            4'd8:    s = 14'b11111111111111;
            4'd9:    s = 14'b11000111111111;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] range_shift(input logic [31:0] mag);
        logic [2:0] s;
        if (mag < MS_10S) begin
            s = 3'd0;
        end else if (mag < MS_1MIN) begin
            s = 3'd1;
        end else if (mag < MS_10MIN) begin
            s = 3'd2;
        end else if (mag < MS_1H) begin
            s = 3'd3;
        end else if (mag < MS_10H) begin
            s = 3'd4;
        end else begin
            s = 3'd5;
        end
        return s;
    endfunction

endpackage

### design/cdsd_split.sv
// eleven-stage pipeline: magnitude, range shift, hours/minutes/seconds/centiseconds split
// and decimal digit extraction; depends on cdsd_pkg
module cdsd_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic signed [31:0]   i_ms_value,
    output logic                 o_valid,
    output cdsd_pkg::t_item      o_item,
    input  logic                 i_ready
);

    localparam int unsigned NST = 11;

    cdsd_pkg::t_work r_st [1:NST];
    cdsd_pkg::t_work n_st [1:NST];
    logic [NST:1]    r_vld;
    logic            w_adv;
    logic [31:0]     w_raw;

    logic [42:0] w_p_hour;
    logic [31:0] w_p_hd;
    logic [31:0] w_h_diff;
    logic [28:0] w_p_min;
    logic [21:0] w_p_md;
    logic [21:0] w_m_diff;
    logic [22:0] w_p_sec;
    logic [15:0] w_p_sd;
    logic [15:0] w_s_diff;
    logic [17:0] w_p_cs;
    logic [15:0] w_p_h2;
    logic [13:0] w_p_m1;
    logic [13:0] w_p_s1;
    logic [14:0] w_p_c1;
    logic [14:0] w_p_h1;
    logic [9:0]  w_hrem;
    logic [5:0]  w_m0;
    logic [5:0]  w_s0;
    logic [6:0]  w_c0;
    logic [6:0]  w_h0;

    assign w_adv  = i_ready || !r_vld[NST];
    assign o_busy = !w_adv;
    assign o_valid = r_vld[NST];
    assign o_item.digits = r_st[NST].digits;
    assign o_item.shift  = r_st[NST].shift;
    assign w_raw = i_ms_value;

    assign w_p_hour = 43'(r_st[1].mag) * 43'(cdsd_pkg::RECIP_HOUR);
    assign w_p_hd   = 32'(r_st[2].hours) * 32'(cdsd_pkg::MS_PER_HOUR);
    assign w_h_diff = r_st[2].mag - w_p_hd;
    assign w_p_min  = 29'(r_st[3].rem[21:0]) * 29'(cdsd_pkg::RECIP_MIN);
    assign w_p_md   = 22'(r_st[4].mins) * 22'(cdsd_pkg::MS_PER_MIN);
    assign w_m_diff = r_st[4].rem[21:0] - w_p_md;
    assign w_p_sec  = 23'(r_st[5].rem[15:0]) * 23'(cdsd_pkg::RECIP_SEC);
    assign w_p_sd   = 16'(r_st[6].secs) * 16'(cdsd_pkg::MS_PER_SEC);
    assign w_s_diff = r_st[6].rem[15:0] - w_p_sd;
    assign w_p_cs   = 18'(r_st[7].rem[9:0]) * 18'(cdsd_pkg::RECIP_TEN);
    assign w_p_h2   = 16'(r_st[7].hours) * 16'(cdsd_pkg::RECIP_HUNDRED);
    assign w_p_m1   = 14'(r_st[7].mins) * 14'(cdsd_pkg::RECIP_TEN);
    assign w_p_s1   = 14'(r_st[7].secs) * 14'(cdsd_pkg::RECIP_TEN);
    assign w_hrem   = r_st[8].hours - 10'(r_st[8].digits[cdsd_pkg::D_H2]) * 10'd100;
    assign w_m0     = r_st[8].mins - 6'(r_st[8].digits[cdsd_pkg::D_M1]) * 6'd10;
    assign w_s0     = r_st[8].secs - 6'(r_st[8].digits[cdsd_pkg::D_S1]) * 6'd10;
    assign w_p_c1   = 15'(r_st[8].centis) * 15'(cdsd_pkg::RECIP_TEN);
    assign w_p_h1   = 15'(r_st[9].hrem) * 15'(cdsd_pkg::RECIP_TEN);
    assign w_c0     = r_st[9].centis - 7'(r_st[9].digits[cdsd_pkg::D_C1]) * 7'd10;
    assign w_h0     = r_st[10].hrem - 7'(r_st[10].digits[cdsd_pkg::D_H1]) * 7'd10;

    always_comb begin
        // magnitude
        n_st[1] = '0;
        n_st[1].mag = w_raw[31] ? (32'd0 - w_raw) : w_raw;

        // range shift and hour estimate
        n_st[2] = r_st[1];
        n_st[2].shift = cdsd_pkg::range_shift(r_st[1].mag);
        n_st[2].hours = w_p_hour[41:32];

        // hour correction and remainder
        n_st[3] = r_st[2];
        if (w_h_diff >= 32'(cdsd_pkg::MS_PER_HOUR)) begin
            n_st[3].hours = r_st[2].hours + 10'd1;
            n_st[3].rem   = 23'(w_h_diff - 32'(cdsd_pkg::MS_PER_HOUR));
        end else begin
            n_st[3].rem   = 23'(w_h_diff);
        end

        // minute estimate
        n_st[4] = r_st[3];
        n_st[4].mins = w_p_min[27:22];

        // minute correction
        n_st[5] = r_st[4];
        if (w_m_diff >= 22'(cdsd_pkg::MS_PER_MIN)) begin
            n_st[5].mins = r_st[4].mins + 6'd1;
            n_st[5].rem  = 23'(w_m_diff - 22'(cdsd_pkg::MS_PER_MIN));
        end else begin
            n_st[5].rem  = 23'(w_m_diff);
        end

        // second estimate
        n_st[6] = r_st[5];
        n_st[6].secs = w_p_sec[21:16];

        // second correction
        n_st[7] = r_st[6];
        if (w_s_diff >= 16'(cdsd_pkg::MS_PER_SEC)) begin
            n_st[7].secs = r_st[6].secs + 6'd1;
            n_st[7].rem  = 23'(w_s_diff - 16'(cdsd_pkg::MS_PER_SEC));
        end else begin
            n_st[7].rem  = 23'(w_s_diff);
        end

        // centiseconds, hours hundreds digit and tens digits
        n_st[8] = r_st[7];
        n_st[8].centis = w_p_cs[17:11];
        n_st[8].digits[cdsd_pkg::D_H2] = w_p_h2[15:12];
        n_st[8].digits[cdsd_pkg::D_M1] = 4'(w_p_m1[13:11]);
        n_st[8].digits[cdsd_pkg::D_S1] = 4'(w_p_s1[13:11]);

        // hours remainder, minute and second units digits and centisecond tens digit
        n_st[9] = r_st[8];
        n_st[9].hrem = w_hrem[6:0];
        n_st[9].digits[cdsd_pkg::D_M0] = w_m0[3:0];
        n_st[9].digits[cdsd_pkg::D_S0] = w_s0[3:0];
        n_st[9].digits[cdsd_pkg::D_C1] = w_p_c1[14:11];

        n_st[10] = r_st[9];
        n_st[10].digits[cdsd_pkg::D_H1] = w_p_h1[14:11];
        n_st[10].digits[cdsd_pkg::D_C0] = w_c0[3:0];

        n_st[11] = r_st[10];
        n_st[11].digits[cdsd_pkg::D_H0] = w_h0[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-1:1], i_start};
        end
        if (w_adv) begin
            for (int k = 1; k <= NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

### design/cdsd_serial.sv
// digit serialiser: walks the display positions of one transaction, one result a cycle,
// with registered result ports; depends on cdsd_pkg
module cdsd_serial #(
    parameter int DIGITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  cdsd_pkg::t_item      i_item,
    output logic                 o_ready,
    output logic                 o_strobe,
    output logic [2:0]           o_digit_position,
    output logic [13:0]          o_segment_pattern,
    output logic [1:0]           o_colour_class,
    output logic                 o_last_digit
);

    localparam int unsigned NDIG = (DIGITS < 1) ? 1 : ((DIGITS > 8) ? 8 : DIGITS);
    localparam logic [2:0] LAST_POS = 3'(NDIG - 1);

    logic              r_active;
    logic [2:0]        r_pos;
    cdsd_pkg::t_item   r_item;
    logic              r_strobe;
    logic [2:0]        r_out_pos;
    logic [13:0]       r_out_seg;
    logic [1:0]        r_out_colour;
    logic              r_out_last;

    logic              w_free;
    logic              w_load;
    logic [3:0]        w_idx;
    logic [2:0]        w_half;
    cdsd_pkg::t_digit  w_digit;
    logic [1:0]        w_colour;

    assign w_free  = !r_active || (r_pos == LAST_POS);
    assign w_load  = i_valid && w_free;
    assign o_ready = w_free;

    assign w_idx    = 4'(LAST_POS - r_pos) + 4'(r_item.shift);
    assign w_digit  = (w_idx < 4'(cdsd_pkg::NUM_DIG)) ? r_item.digits[w_idx] : '0;
    assign w_half   = w_idx[3:1];
    assign w_colour = (w_half > 3'd3) ? 2'd3 : w_half[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (w_load) begin
                r_active <= 1'b1;
                r_pos    <= '0;
            end else if (r_active && (r_pos == LAST_POS)) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_pos <= r_pos + 3'd1;
            end
        end
        if (w_load) begin
            r_item <= i_item;
        end
        if (r_active) begin
            r_out_pos    <= r_pos;
            r_out_seg    <= cdsd_pkg::seg_code(w_digit);
            r_out_colour <= w_colour;
            r_out_last   <= (r_pos == LAST_POS);
        end
    end

    assign o_strobe          = r_strobe;
    assign o_digit_position  = r_out_pos;
    assign o_segment_pattern = r_out_seg;
    assign o_colour_class    = r_out_colour;
    assign o_last_digit      = r_out_last;

endmodule

### design/countdown_ms_to_segment_digits.sv
// top level of the countdown display encoder: digit split pipeline and serialiser
// depends on cdsd_pkg, cdsd_split and cdsd_serial
//
// usage
//   a transaction is taken on the rising edge where start is high and busy is low;
//   i_ms_value is a signed millisecond count, only its magnitude is used
//   each transaction yields DIGITS results (clamped to 1..8), leftmost position first,
//   one per cycle on consecutive cycles, each marked by o_strobe for one cycle;
//   o_last_digit flags the rightmost position
//   the accepting edge fills stage one; a transaction then passes ten more stages,
//   the serialiser load and the result register before its first result is shown
//   throughput: the serialiser emits one position a cycle and takes the next
//   transaction while emitting the last position; start may be held high and is taken
//   whenever busy is low, so back-to-back transactions give gapless bursts
//   busy rises when a finished transaction waits at the pipeline end for
//   the serialiser; the whole pipeline then holds and nothing is dropped
//   the receiver cannot stall: results are shown exactly once, for one cycle
//   reset (synchronous, active low) empties the pipeline and the serialiser;
//   no result is shown until a new transaction has gone through
module countdown_ms_to_segment_digits #(
    parameter int DIGITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_ms_value,
    output logic                 o_strobe,
    output logic [2:0]           o_digit_position,
    output logic [13:0]          o_segment_pattern,
    output logic [1:0]           o_colour_class,
    output logic                 o_last_digit
);

    logic              w_valid;
    logic              w_ready;
    cdsd_pkg::t_item   w_item;

    cdsd_split u_split (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_ms_value (i_ms_value),
        .o_valid    (w_valid),
        .o_item     (w_item),
        .i_ready    (w_ready)
    );

    cdsd_serial #(
        .DIGITS (DIGITS)
    ) u_serial (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_valid),
        .i_item            (w_item),
        .o_ready           (w_ready),
        .o_strobe          (o_strobe),
        .o_digit_position  (o_digit_position),
        .o_segment_pattern (o_segment_pattern),
        .o_colour_class    (o_colour_class),
        .o_last_digit      (o_last_digit)
    );

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_digit |=>
            o_strobe && (o_digit_position == $past(o_digit_position) + 3'd1))
        else $error("burst broken or position skipped");

    a_colour_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_digit |=> o_colour_class <= $past(o_colour_class))
        else $error("colour class rises towards the right");

    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_digit_position == 3'd0) |->
            !$past(o_strobe) || $past(o_last_digit))
        else $error("new burst began before the previous one ended");

endmodule
